FILE: src/b2dt_pkg.sv
// ----------------------------------------------------------------------------
// b2dt_pkg
// Shared types and constants for the binary to decimal text converter.
// ----------------------------------------------------------------------------
package b2dt_pkg;

   // default width of the converted number
   localparam int VALUE_BITS_DEF = 32;

   // configuration port
   localparam int   CSR_ADDR_W  = 3;
   localparam logic CSR_SEP_IDX = 1'b0;   // word index of separator_char

   // character codes
   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_MINUS = 8'h2D;

   // digits per separator group
   localparam int GROUP_DIGITS = 3;

   typedef struct packed {
      logic        func;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [7:0] text_char;
      logic       last_char;
      logic [3:0] text_length;
   } rsp_type;

endpackage

FILE: src/b2dt_dabble.sv
// ----------------------------------------------------------------------------
// b2dt_dabble
// Iterative binary to BCD unit: one shift-add-3 step per cycle.
// ----------------------------------------------------------------------------
module b2dt_dabble
   import b2dt_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int DIGITS     = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [VALUE_BITS-1:0]   bin,
   output logic                    done,
   output logic [4*DIGITS-1:0]     bcd
);

   localparam int CW = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0] bin_ff;
   logic [4*DIGITS-1:0]   bcd_ff;
   logic [4*DIGITS-1:0]   adj_in;
   logic [CW-1:0]         cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;

   // add 3 to every digit of 5 or more before the shift
   always_comb begin
      for (int d = 0; d < DIGITS; d++) begin
         adj_in[4*d +: 4] = (bcd_ff[4*d +: 4] >= 4'd5) ? bcd_ff[4*d +: 4] + 4'd3
                                                        : bcd_ff[4*d +: 4];
      end
   end

   // step sequencer, one input bit per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(VALUE_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         bin_ff <= bin;
         bcd_ff <= '0;
      end else if (busy_ff) begin
         bcd_ff <= {adj_in[4*DIGITS-2:0], bin_ff[VALUE_BITS-1]};
         bin_ff <= {bin_ff[VALUE_BITS-2:0], 1'b0};
      end
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

FILE: src/binary_to_decimal_text.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_text
// Converts a number to its decimal ASCII text, one character per beat.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one beat carries func (0 unsigned, 1 signed) and value.
//   rsp channel: one beat per character, most significant first, a leading
//   '-' for a negative signed value, separator_char between groups of three
//   digits when that register is nonzero. last_char marks the final beat,
//   text_length (total characters) rides on every beat.
//   APB port: separator_char at address 0, written with psel/penable/pwrite,
//   pready tied high.
// Timing:
//   The shift-add-3 unit takes one input bit per cycle; the sequencer then
//   picks up its done flag and sizes the text in ST_SIZE before the first
//   character is registered. Characters then go out one per cycle while
//   rsp_ready holds; a text is at most 14 characters at 32 bits.
//   req_ready is high only between numbers; the last character may still
//   sit in the output register while the next number is taken.
// Reset clears the sequencer, the output valid and separator_char.
// A stalled rsp holds its beat; the sequencer waits on the output register.
// ----------------------------------------------------------------------------
module binary_to_decimal_text
   import b2dt_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int DIGITS = (VALUE_BITS * 1233) / 4096 + 1;
   localparam int MAXCH  = 1 + DIGITS + (DIGITS - 1) / GROUP_DIGITS;
   localparam int DW     = $clog2(DIGITS + 1);
   localparam int IW     = $clog2(DIGITS);
   localparam int LW     = $clog2(MAXCH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIZE,
      ST_EMIT
   } state_type;

   state_type             state_ff;
   logic [7:0]            sep_ff;
   logic                  neg_ff;
   logic                  sep_en_ff;
   logic [DW-1:0]         ndig_ff;
   logic                  size_ph_ff;
   logic [DW-1:0]         rem_ff;
   logic [1:0]            grp_ff;
   logic [LW-1:0]         left_ff;
   logic [LW-1:0]         length_ff;
   logic                  neg_pend_ff;
   logic                  sep_pend_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_ff;

   logic                  req_fire;
   logic                  neg_in;
   logic [VALUE_BITS-1:0] raw_in;
   logic [VALUE_BITS-1:0] mag_in;
   logic                  dab_done;
   logic [4*DIGITS-1:0]   bcd;
   logic [DW-1:0]         ndig_in;
   logic [DW-1:0]         seps_in;
   logic [1:0]            lead_in;
   logic [LW-1:0]         total_in;
   logic [DW-1:0]         rem_m1;
   logic [3:0]            digit;
   logic                  load;

   // configuration port
   assign pready = 1'b1;
   assign prdata = (paddr[2] == CSR_SEP_IDX) ? {24'd0, sep_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sep_ff <= 8'd0;
      end else if (psel && penable && pwrite && paddr[2] == CSR_SEP_IDX) begin
         sep_ff <= pwdata[7:0];
      end
   end

   // sign handling at accept
   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign raw_in    = VALUE_BITS'(req_data.value);
   assign neg_in    = req_data.func && raw_in[VALUE_BITS-1];
   assign mag_in    = neg_in ? (~raw_in + 1'b1) : raw_in;

   b2dt_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .DIGITS     (DIGITS)
   ) u_dabble (
      .clock (clock),
      .reset (reset),
      .start (req_fire),
      .bin   (mag_in),
      .done  (dab_done),
      .bcd   (bcd)
   );

   // count of significant digits, zero counts as one
   always_comb begin
      ndig_in = DW'(1);
      for (int d = 0; d < DIGITS; d++) begin
         if (bcd[4*d +: 4] != 4'd0) ndig_in = DW'(d + 1);
      end
   end

   // separators, digits ahead of the first one, and total length
   always_comb begin
      seps_in = '0;
      for (int i = 1; i < DIGITS; i++) begin
         if (int'(ndig_ff) > GROUP_DIGITS * i) seps_in = seps_in + 1'b1;
      end
      lead_in  = 2'(int'(ndig_ff) - GROUP_DIGITS * int'(seps_in));
      total_in = LW'(neg_ff) + LW'(ndig_ff) + (sep_en_ff ? LW'(seps_in) : LW'(0));
   end

   // current digit, most significant remaining
   assign rem_m1 = rem_ff - 1'b1;
   assign digit  = bcd[4*rem_m1[IW-1:0] +: 4];
   assign load   = !rsp_valid_ff || rsp_ready;

   // sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         size_ph_ff   <= 1'b0;
         neg_pend_ff  <= 1'b0;
         sep_pend_ff  <= 1'b0;
         left_ff      <= '0;
      end else begin
         // final beat drains once the sequencer has left emit
         if (rsp_valid_ff && rsp_ready && state_ff != ST_EMIT) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  neg_ff    <= neg_in;
                  sep_en_ff <= (sep_ff != 8'd0);
                  state_ff  <= ST_CONV;
               end
            end
            ST_CONV: begin
               if (dab_done) begin
                  size_ph_ff <= 1'b0;
                  state_ff   <= ST_SIZE;
               end
            end
            ST_SIZE: begin
               if (!size_ph_ff) begin
                  ndig_ff    <= ndig_in;
                  size_ph_ff <= 1'b1;
               end else begin
                  rem_ff      <= ndig_ff;
                  grp_ff      <= lead_in;
                  left_ff     <= total_in;
                  length_ff   <= total_in;
                  neg_pend_ff <= neg_ff;
                  sep_pend_ff <= 1'b0;
                  state_ff    <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (load) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.last_char    <= (left_ff == LW'(1));
                  rsp_ff.text_length  <= 4'(length_ff);
                  left_ff             <= left_ff - 1'b1;
                  priority if (neg_pend_ff) begin
                     rsp_ff.text_char <= ASCII_MINUS;
                     neg_pend_ff      <= 1'b0;
                  end else if (sep_pend_ff) begin
                     rsp_ff.text_char <= sep_ff;
                     sep_pend_ff      <= 1'b0;
                  end else begin
                     rsp_ff.text_char <= ASCII_ZERO + {4'd0, digit};
                     rem_ff           <= rem_m1;
                     if (grp_ff == 2'd1) begin
                        grp_ff <= 2'(GROUP_DIGITS);
                        if (rem_ff != DW'(1) && sep_en_ff) sep_pend_ff <= 1'b1;
                     end else begin
                        grp_ff <= grp_ff - 1'b1;
                     end
                  end
                  if (left_ff == LW'(1)) state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high right after an accepted number");

   a_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      dab_done |-> state_ff == ST_CONV)
      else $error("conversion finished outside the conversion phase");

   a_more_to_come: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_char |-> left_ff != '0 && state_ff == ST_EMIT)
      else $error("non-final character with nothing left to send");

   a_idle_drained: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> left_ff == '0)
      else $error("ready for a number while characters remain");

endmodule

FILE: dv/binary_to_decimal_text_test.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_text_test
// Self-checking bench for the binary to decimal text converter. Numbers go
// in on the req channel. A scoreboard class builds the expected characters
// from its own converter and compares every rsp beat, field by field.
// The separator register is changed between phases while the block is idle.
// Corner numbers come first, then random numbers with random idling on both
// channels, and one phase runs with no idling at all.
// ----------------------------------------------------------------------------
module binary_to_decimal_text_test
   import b2dt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // expected characters per number, checked in order of arrival
   class text_scoreboard;
      rsp_type pending_chars[$];
      int      errors;

      // build the decimal text of one accepted number
      function void note_number(req_type item, logic [7:0] sep);
         logic        neg;
         logic [31:0] mag;
         logic [7:0]  chars[$];
         int          group;
         int          n;
         rsp_type     beat;
         neg   = item.func && item.value[31];
         mag   = neg ? (~item.value + 32'd1) : item.value;
         group = 0;
         // digits from the right, a separator after every three digits
         do begin
            if (group == GROUP_DIGITS && sep != 8'd0) begin
               chars.push_front(sep);
               group = 0;
            end
            chars.push_front(ASCII_ZERO + 8'(mag % 32'd10));
            mag = mag / 32'd10;
            group++;
         end while (mag != 32'd0);
         if (neg) chars.push_front(ASCII_MINUS);
         n = chars.size();
         foreach (chars[k]) begin
            beat.text_char   = chars[k];
            beat.last_char   = (k == n - 1);
            beat.text_length = 4'(n);
            pending_chars.push_back(beat);
         end
      endfunction

      function void check_char(rsp_type got);
         rsp_type want;
         if (pending_chars.size() == 0) begin
            $error("rsp beat with nothing expected: char %h", got.text_char);
            errors++;
            return;
         end
         want = pending_chars.pop_front();
         if (got.text_char !== want.text_char) begin
            $error("text_char expected %h actual %h", want.text_char, got.text_char);
            errors++;
         end
         if (got.last_char !== want.last_char) begin
            $error("last_char expected %b actual %b", want.last_char, got.last_char);
            errors++;
         end
         if (got.text_length !== want.text_length) begin
            $error("text_length expected %0d actual %0d",
                   want.text_length, got.text_length);
            errors++;
         end
      endfunction

      function bit busy();
         return pending_chars.size() != 0;
      endfunction

      function void report_leftover();
         if (pending_chars.size() != 0) begin
            $error("%0d characters never arrived", pending_chars.size());
            errors++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_data;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   text_scoreboard text_board = new();
   logic [7:0]     sep_now;
   int             idle_pct;

   binary_to_decimal_text uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop if the block hangs
   initial begin
      #4_000_000;
      $display("binary_to_decimal_text regression: fail");
      $finish;
   end

   // rsp side: check accepted beats, stall at random
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) text_board.check_char(rsp_data);
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   // APB write: setup cycle, then access until pready
   task write_csr(input int index, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(4 * index);
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (index == CSR_SEP_IDX) sep_now = data[7:0];
   endtask

   // one req beat, with an optional idle gap ahead of it
   task drive_number(input req_type item);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      text_board.note_number(item, sep_now);
   endtask

   // stop sending and wait for every expected character
   task drain;
      req_valid <= 1'b0;
      while (text_board.busy()) @(posedge clock);
   endtask

   function req_type random_number();
      req_type     item;
      logic [31:0] p;
      item.func = 1'($urandom_range(1));
      case ($urandom_range(4))
         0: item.value = $urandom;
         1: item.value = $urandom_range(9999);
         2: item.value = 32'd0 - $urandom_range(99999);
         3: begin
            // around a power of ten, where group boundaries move
            p = 32'd1;
            repeat ($urandom_range(9)) p = p * 32'd10;
            item.value = p + $urandom_range(2) - 32'd1;
         end
         default: item.value = ($urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFC)
                               + $urandom_range(3);
      endcase
      return item;
   endfunction

   task run_random(input logic [7:0] sep, input int count);
      write_csr(CSR_SEP_IDX, {24'd0, sep});
      repeat (count) drive_number(random_number());
      drain();
   endtask

   initial begin
      req_type corner_list[$];
      req_valid = 1'b0;
      req_data  = '0;
      rsp_ready = 1'b0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      reset     = 1'b1;
      sep_now   = 8'd0;
      idle_pct  = 28;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zeros, full range ends, most negative, group edges
      corner_list.push_back('{1'b0, 32'd0});
      corner_list.push_back('{1'b1, 32'd0});
      corner_list.push_back('{1'b0, 32'hFFFF_FFFF});
      corner_list.push_back('{1'b1, 32'hFFFF_FFFF});
      corner_list.push_back('{1'b1, 32'h8000_0000});
      corner_list.push_back('{1'b0, 32'h8000_0000});
      corner_list.push_back('{1'b1, 32'h7FFF_FFFF});
      corner_list.push_back('{1'b0, 32'd999});
      corner_list.push_back('{1'b0, 32'd1000});
      corner_list.push_back('{1'b0, 32'd1000000});
      corner_list.push_back('{1'b1, 32'hFFFF_FC18});
      corner_list.push_back('{1'b0, 32'd7});

      write_csr(CSR_SEP_IDX, 32'h2C);
      foreach (corner_list[i]) drive_number(corner_list[i]);
      drain();
      write_csr(CSR_SEP_IDX, 32'h0);
      foreach (corner_list[i]) drive_number(corner_list[i]);
      drain();

      run_random(8'hFF, 55);
      idle_pct = 0;
      run_random(8'h01, 55);
      idle_pct = 28;
      run_random(8'($urandom_range(255, 1)), 55);
      run_random(8'h00, 55);

      // catch any stray beats after the last character
      repeat (60) @(posedge clock);
      text_board.report_leftover();
      if (text_board.errors == 0) begin
         $display("binary_to_decimal_text regression: pass");
      end else begin
         $display("binary_to_decimal_text regression: fail");
      end
      $finish;
   end

endmodule
